[design/btc_pkg.sv]
// ----------------------------------------------------------------------------
// btc_pkg
// Shared constants and types for the button tap/hold classifier.
// ----------------------------------------------------------------------------
package btc_pkg;

  localparam int unsigned NUM_BUTTONS = 6;
  localparam int unsigned NUM_FIELDS  = 6;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned THR_WIDTH   = 16;
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

  // lanes actually built: buttons with an input bit behind them
  localparam int unsigned NUM_LANES = (NUM_BUTTONS < NUM_FIELDS) ? NUM_BUTTONS : NUM_FIELDS;

  localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET = THR_WIDTH'(1000);

  typedef logic [1:0]                   evt_t;
  typedef logic [NUM_FIELDS-1:0][1:0]   evt_vec_t;
  typedef logic [COUNT_WIDTH-1:0]       count_t;
  typedef logic [THR_WIDTH-1:0]         thr_t;

  localparam evt_t EV_NONE = 2'd0;
  localparam evt_t EV_JOG  = 2'd1;
  localparam evt_t EV_STEP = 2'd2;
  localparam evt_t EV_STOP = 2'd3;

  // handshake status between the output stage and the lanes
  typedef struct packed {
    logic accept;   // an item is taken this cycle
    logic ready;    // output stage can take a result
  } flow_t;

endpackage

[design/btc_lane.sv]
// ----------------------------------------------------------------------------
// btc_lane
// One button: hold counter, edge detect and tap/hold classification.
// ----------------------------------------------------------------------------
module btc_lane (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  btc_pkg::flow_t flow_i,
  input  logic          level_i,
  input  btc_pkg::thr_t threshold_i,
  output btc_pkg::evt_t evt_o
);

  localparam btc_pkg::count_t CntMax = {btc_pkg::COUNT_WIDTH{1'b1}};

  btc_pkg::count_t cnt_q, cnt_d;
  logic            prev_q;
  logic            jog_q, jog_d;
  logic [btc_pkg::CMP_WIDTH-1:0] cnt_ext, cnt_d_ext, thr_ext;

  assign cnt_ext   = btc_pkg::CMP_WIDTH'(cnt_q);
  assign cnt_d_ext = btc_pkg::CMP_WIDTH'(cnt_d);
  assign thr_ext   = btc_pkg::CMP_WIDTH'(threshold_i);

  always_comb begin
    cnt_d = cnt_q;
    jog_d = jog_q;
    evt_o = btc_pkg::EV_NONE;
    if (level_i) begin
      if (cnt_q != CntMax) cnt_d = cnt_q + 1'b1;   // saturate, no wrap
      if ((cnt_d_ext >= thr_ext) && !jog_q) begin
        jog_d = 1'b1;
        evt_o = btc_pkg::EV_JOG;
      end
    end else if (prev_q) begin
      evt_o = (cnt_ext < thr_ext) ? btc_pkg::EV_STEP : btc_pkg::EV_STOP;
      cnt_d = '0;
      jog_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= 1'b0;
      jog_q  <= 1'b0;
    end else if (flow_i.accept) begin
      cnt_q  <= cnt_d;
      prev_q <= level_i;
      jog_q  <= jog_d;
    end
  end

  // a count or a jog flag only survives while the button is down
  a_cnt_needs_press : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> prev_q) else $error("hold count set with button released");

  a_jog_needs_press : assert property (@(posedge clk_i) disable iff (!rst_ni)
    jog_q |-> prev_q) else $error("jog flag set with button released");

  a_release_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flow_i.accept && !level_i && prev_q) |=> ((cnt_q == '0) && !jog_q))
    else $error("release did not clear lane state");

endmodule

[design/btc_merge.sv]
// ----------------------------------------------------------------------------
// btc_merge
// Gathers the lane events into one result item and holds it in the output
// register until it is taken.
// ----------------------------------------------------------------------------
module btc_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  btc_pkg::evt_t     lane_evt_i [btc_pkg::NUM_LANES],
  output btc_pkg::flow_t    flow_o,
  output logic              out_valid_o,
  output btc_pkg::evt_vec_t evt_o
);

  logic              valid_q, valid_d;
  btc_pkg::evt_vec_t evt_q, evt_d;

  always_comb begin
    flow_o.ready  = !valid_q || out_ready_i;
    flow_o.accept = in_valid_i && flow_o.ready;
  end

  // unbuilt lanes always report none
  always_comb begin
    evt_d = '{default: btc_pkg::EV_NONE};
    for (int unsigned i = 0; i < btc_pkg::NUM_LANES; i++) begin
      evt_d[i] = lane_evt_i[i];
    end
  end

  assign valid_d = flow_o.accept || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_o.accept) evt_q <= evt_d;
  end

  assign out_valid_o = valid_q;
  assign evt_o       = evt_q;

  // every accepted item shows up as a result the next cycle
  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flow_o.accept |=> valid_q) else $error("accepted item produced no result");

  a_no_accept_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |-> !flow_o.accept)
    else $error("item accepted over a pending result");

  a_idle_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!flow_o.accept && out_ready_i) |=> !valid_q)
    else $error("result repeated");

endmodule

[design/button_tap_hold_classifier.sv]
// ----------------------------------------------------------------------------
// button_tap_hold_classifier
// Six-button tap/hold classifier: jog start, step and stop events per tick.
// ----------------------------------------------------------------------------
// One item is one tick of button levels and yields exactly one result item,
// in the cycle after acceptance, carrying a 2-bit event per button (none, jog
// start, step, stop). Each button has its own lane with a saturating hold
// counter, so a new item is taken every cycle; the only limit is the single
// output register, which accepts a new item in the same cycle that the
// pending result is taken. hold_threshold is written via cfg_we_i and takes
// effect from the next item; reset value is 1000.
module button_tap_hold_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [5:0] button_levels_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] event_left_o,
  output logic [1:0] event_right_o,
  output logic [1:0] event_in_o,
  output logic [1:0] event_out_o,
  output logic [1:0] event_up_o,
  output logic [1:0] event_down_o
);

  btc_pkg::thr_t     thr_q;
  btc_pkg::flow_t    flow;
  btc_pkg::evt_t     lane_evt [btc_pkg::NUM_LANES];
  btc_pkg::evt_vec_t evt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= btc_pkg::THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      thr_q <= btc_pkg::THR_WIDTH'(cfg_wdata_i);
    end
  end

  for (genvar g = 0; g < btc_pkg::NUM_LANES; g++) begin : g_lane
    btc_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .flow_i      (flow),
      .level_i     (button_levels_i[g]),
      .threshold_i (thr_q),
      .evt_o       (lane_evt[g])
    );
  end

  btc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .lane_evt_i  (lane_evt),
    .flow_o      (flow),
    .out_valid_o (out_valid_o),
    .evt_o       (evt)
  );

  assign in_ready_o    = flow.ready;
  assign event_left_o  = evt[0];
  assign event_right_o = evt[1];
  assign event_in_o    = evt[2];
  assign event_out_o   = evt[3];
  assign event_up_o    = evt[4];
  assign event_down_o  = evt[5];

endmodule

[verif/button_tap_hold_classifier_test.sv]
// ----------------------------------------------------------------------------
// button_tap_hold_classifier_test
// Self-checking bench for the six-button tap/hold classifier.
// ----------------------------------------------------------------------------
// A queue of button ticks feeds a valid/ready driver. Each accepted tick goes
// through a local model of the per-button hold counters, and the predicted
// event vector is queued. A monitor takes the results under random
// back-pressure and checks every event field against the oldest prediction.
// The threshold is changed between phases while the block is idle. Phases:
// directed taps and holds at threshold 0, 1, 2 and reset, random press
// sequences at small thresholds, a long hold at the top threshold where
// no press ever turns into a jog, and random presses at the reset threshold.
// ----------------------------------------------------------------------------
module button_tap_hold_classifier_test;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned IDLE_PCT    = 20;

  logic        clk_i       = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [15:0] cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic [5:0]  levels      = '0;
  logic        out_ready   = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  ev_left, ev_right, ev_in, ev_out, ev_up, ev_down;

  logic [5:0]           tick_q[$];
  btc_pkg::evt_vec_t    event_q[$];
  int unsigned          mismatch_cnt = 0;
  int unsigned          cycle_cnt    = 0;
  logic                 calm;

  // local copy of the lane state
  btc_pkg::thr_t        hold_thr;
  btc_pkg::count_t      held_ticks[btc_pkg::NUM_BUTTONS];
  logic                 last_level[btc_pkg::NUM_BUTTONS];
  logic                 jogging[btc_pkg::NUM_BUTTONS];

  string       field_name[btc_pkg::NUM_FIELDS] = '{"left", "right", "in", "out", "up", "down"};

  button_tap_hold_classifier uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .button_levels_i (levels),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .event_left_o    (ev_left),
    .event_right_o   (ev_right),
    .event_in_o      (ev_in),
    .event_out_o     (ev_out),
    .event_up_o      (ev_up),
    .event_down_o    (ev_down)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // no idling on either side through this stretch
  assign calm = (cycle_cnt >= 400) && (cycle_cnt < 900);

  function automatic btc_pkg::evt_vec_t classify_tick(input logic [5:0] lv);
    btc_pkg::evt_vec_t ev;
    ev = '0;
    for (int b = 0; b < btc_pkg::NUM_BUTTONS && b < btc_pkg::NUM_FIELDS; b++) begin
      ev[b] = btc_pkg::EV_NONE;
      if (lv[b]) begin
        if (held_ticks[b] != '1) held_ticks[b] = held_ticks[b] + 1'b1;
        if (held_ticks[b] >= hold_thr && !jogging[b]) begin
          jogging[b] = 1'b1;
          ev[b] = btc_pkg::EV_JOG;
        end
      end else if (last_level[b]) begin
        ev[b] = (held_ticks[b] < hold_thr) ? btc_pkg::EV_STEP : btc_pkg::EV_STOP;
        held_ticks[b] = '0;
        jogging[b] = 1'b0;
      end
      last_level[b] = lv[b];
    end
    return ev;
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL button_tap_hold_classifier");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      levels   <= '0;
    end else begin
      if (in_valid && in_ready_o) event_q.push_back(classify_tick(levels));
      if (!in_valid || in_ready_o) begin
        if (tick_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          levels   <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_n) begin
    btc_pkg::evt_vec_t want;
    btc_pkg::evt_vec_t got;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        got = {ev_down, ev_up, ev_out, ev_in, ev_right, ev_left};
        if (event_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result item %h", got);
        end else begin
          want = event_q.pop_front();
          for (int f = 0; f < btc_pkg::NUM_FIELDS; f++) begin
            if (got[f] !== want[f]) begin
              mismatch_cnt++;
              if (mismatch_cnt <= 10)
                $display("event_%s mismatch: expected %0d, got %0d",
                         field_name[f], want[f], got[f]);
            end
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic wait_idle();
    while (tick_q.size() != 0 || in_valid || event_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_threshold(input btc_pkg::thr_t value);
    wait_idle();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    hold_thr   = value;
    @(negedge clk_i);
  endtask

  // presses of random length around the threshold, with some noise ticks
  task automatic queue_press_runs(input int unsigned n, input int unsigned thr);
    logic [5:0]  lv;
    int unsigned run[btc_pkg::NUM_FIELDS];
    int unsigned t;
    lv = '0;
    t  = (thr == 0) ? 1 : thr;
    for (int b = 0; b < btc_pkg::NUM_FIELDS; b++) run[b] = $urandom_range(1, 3);
    for (int unsigned k = 0; k < n; k++) begin
      for (int b = 0; b < btc_pkg::NUM_FIELDS; b++) begin
        if (run[b] == 0) begin
          lv[b] = ~lv[b];
          if (!lv[b]) run[b] = $urandom_range(1, 4);
          else case ($urandom_range(2))
            0:       run[b] = $urandom_range(1, t);
            1:       run[b] = t;
            default: run[b] = t + $urandom_range(0, 2 * t + 3);
          endcase
        end
        run[b]--;
      end
      if ($urandom_range(99) < 15) tick_q.push_back(6'($urandom));
      else tick_q.push_back(lv);
    end
  endtask

  initial begin
    btc_pkg::thr_t thr_list[8];
    hold_thr = btc_pkg::THRESHOLD_RESET;
    for (int b = 0; b < btc_pkg::NUM_BUTTONS; b++) begin
      held_ticks[b] = '0;
      last_level[b] = 1'b0;
      jogging[b]    = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // reset threshold: short taps, each button alone and in groups
    tick_q.push_back(6'h00); tick_q.push_back(6'h3F); tick_q.push_back(6'h00);
    tick_q.push_back(6'h15); tick_q.push_back(6'h2A); tick_q.push_back(6'h00);
    for (int b = 0; b < btc_pkg::NUM_FIELDS; b++) tick_q.push_back(6'(1 << b));
    tick_q.push_back(6'h00);

    // threshold zero: jog on the first held tick, stop on release
    write_threshold(16'd0);
    tick_q.push_back(6'h3F); tick_q.push_back(6'h3F); tick_q.push_back(6'h00);
    tick_q.push_back(6'h2A); tick_q.push_back(6'h00);

    write_threshold(16'd1);
    tick_q.push_back(6'h3F); tick_q.push_back(6'h3F); tick_q.push_back(6'h00);

    write_threshold(16'd2);
    tick_q.push_back(6'h3F); tick_q.push_back(6'h00);
    tick_q.push_back(6'h3F); tick_q.push_back(6'h3F); tick_q.push_back(6'h3F);
    tick_q.push_back(6'h00);

    thr_list = '{16'd1, 16'd2, 16'd3, 16'd5, 16'd8, 16'd0, 16'd4,
                 16'($urandom_range(1, 12))};
    for (int p = 0; p < 8; p++) begin
      write_threshold(thr_list[p]);
      if (p == 3) begin
        queue_press_runs(45, thr_list[p]);
        wait_idle();
        queue_press_runs(45, thr_list[p]);
      end else begin
        queue_press_runs(90, thr_list[p]);
      end
    end

    // top threshold: long holds never jog, every release is a step
    write_threshold(16'hFFFF);
    for (int unsigned n = 0; n < 40; n++)
      tick_q.push_back((n < 38) ? 6'h3F : 6'h3E);
    tick_q.push_back(6'h00);
    tick_q.push_back(6'h3F);
    tick_q.push_back(6'h00);

    write_threshold(btc_pkg::THRESHOLD_RESET);
    queue_press_runs(20, 3);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0 && event_q.size() == 0) begin
      $display("PASS button_tap_hold_classifier");
    end else begin
      $display("FAIL button_tap_hold_classifier");
    end
    $finish;
  end

endmodule
